// File: design/tfl_pkg.sv
package tfl_pkg;

    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int COUNT_W = 5;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // one stored translation
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    // one finished response
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

// File: design/tfl_mem.sv
module tfl_mem #(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  tfl_pkg::entry_t          wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output tfl_pkg::entry_t          rd_data
);
    import tfl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/tfl_ctrl.sv
module tfl_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [1:0]               req_type,
    input  logic [tfl_pkg::PAGE_W-1:0]  req_page,
    input  logic [tfl_pkg::FRAME_W-1:0] req_frame,
    output logic                     res_valid,
    input  logic                     res_ready,
    output tfl_pkg::res_t            res,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output tfl_pkg::entry_t          wr_data,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    input  tfl_pkg::entry_t          rd_data
);
    import tfl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int EXT_W = CNT_W + COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    res_t              res_reg, res_next;

    logic              accept;
    logic [IDX_W-1:0]  slot_inc;
    logic [IDX_W-1:0]  oldest_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_slot;
    logic [CNT_W-1:0]  k_plus;
    logic [EXT_W-1:0]  fill_ext;

    assign accept = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_HOLD);
    assign res = res_reg;

    // ring index arithmetic, depth need not be a power of two
    assign slot_inc   = (slot_reg == IDX_W'(DEPTH - 1)) ? '0 : slot_reg + IDX_W'(1);
    assign oldest_inc = (oldest_reg == IDX_W'(DEPTH - 1)) ? '0 : oldest_reg + IDX_W'(1);
    assign tail_sum   = SUM_W'(oldest_reg) + SUM_W'(fill_reg);
    assign tail_slot  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                    : IDX_W'(tail_sum);
    assign k_plus     = k_reg + CNT_W'(1);
    assign fill_ext   = EXT_W'(fill_next);

    assign rd_addr = (state_reg == ST_SCAN) ? slot_inc : oldest_reg;
    assign wr_data = '{page: req_page, frame: req_frame};

    always_comb begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        page_next   = page_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_slot;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next.hit   = 1'b0;
                    res_next.frame = '0;
                    page_next      = req_page;
                    state_next     = ST_HOLD;
                    case (req_type)
                        REQ_LOOKUP: begin
                            slot_next = oldest_reg;
                            k_next    = '0;
                            if (fill_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_INSERT: begin
                            wr_en = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH)) begin
                                wr_addr     = oldest_reg;
                                oldest_next = oldest_inc;
                            end else begin
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        REQ_CLEAR: begin
                            oldest_next = '0;
                            fill_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                    res_next.count = fill_ext[COUNT_W-1:0];
                end
            end
            ST_SCAN: begin
                // rd_data holds slot_reg, read last cycle
                if (rd_data.page == page_reg) begin
                    res_next.hit   = 1'b1;
                    res_next.frame = rd_data.frame;
                    state_next     = ST_HOLD;
                end else if (k_plus == fill_reg) begin
                    state_next = ST_HOLD;
                end else begin
                    slot_next = slot_inc;
                    k_next    = k_plus;
                end
            end
            ST_HOLD: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            fill_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
        end
        slot_reg <= slot_next;
        k_reg    <= k_next;
        page_reg <= page_next;
        res_reg  <= res_next;
    end

endmodule

// File: design/tlb_fifo_lookup_insert_core.sv
// fully associative translation buffer, page number to frame number, with
// first-in first-out replacement and a clear-all request
//
// input channel s_*: one request per handshake, s_req_type selects lookup,
// insert or clear; type 3 changes nothing and just reports the count
// result channel m_*: exactly one response per request, in order
//
// entries sit in a single-port-write, registered-read memory as a ring
// ordered by age; a lookup reads the ring from the oldest entry one slot per
// cycle and stops at the first match, so the oldest match wins
// insert and clear need no scan; a lookup that matches the (j+1)-th oldest
// entry reads j+1 slots and a miss reads every stored entry, up to TLB_ENTRIES,
// so lookup time is set by the one-read-per-cycle memory scan
// a finished response passes from the sequencer's hold state through the
// output register to m_valid
//
// reset (synchronous, aresetn low) empties the buffer; memory contents are
// not cleared, only the fill count and oldest pointer
// while m_ready is low the finished response waits in the output register
// and one more completed response waits in the sequencer; no new request is
// taken until the sequencer has handed its response on
module tlb_fifo_lookup_insert_core #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [tfl_pkg::PAGE_W-1:0]  s_page_number,
    input  logic [tfl_pkg::FRAME_W-1:0] s_frame_number,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [tfl_pkg::FRAME_W-1:0] m_frame_out,
    output logic [tfl_pkg::COUNT_W-1:0] m_entry_count
);
    import tfl_pkg::*;

    localparam int IDX_W = $clog2(TLB_ENTRIES);

    // memory side
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;

    // sequencer to output register
    logic              res_valid;
    logic              res_ready;
    res_t              res;

    // output register
    logic              m_valid_reg, m_valid_next;
    res_t              out_reg, out_next;

    tfl_mem #(
        .DEPTH (TLB_ENTRIES)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // request sequencer: pointers, fill count and lookup scan
    tfl_ctrl #(
        .DEPTH (TLB_ENTRIES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_type  (s_req_type),
        .req_page  (s_page_number),
        .req_frame (s_frame_number),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // output register loads whenever it is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = out_reg.hit;
    assign m_frame_out   = out_reg.frame;
    assign m_entry_count = out_reg.count;

endmodule
